### rtl/sag_pkg.sv
// shared types and constants of the sample acquisition gate
package sag_pkg;

  // request opcodes
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_ARM    = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_FAST   = 2'd0;
  localparam logic [1:0] REG_PER_TRIG   = 2'd1;
  localparam logic [1:0] REG_WIN_COUNT  = 2'd2;

  // reset value of the per-trigger grant
  localparam logic [23:0] GRANT_DEFAULT = 24'd500;

  // one table entry: count in the upper bits, raw period in the lower bits
  localparam int ENTRY_W = 40;

  typedef struct packed {
    logic [23:0] max_fast_points;
    logic [23:0] points_per_trigger;
    logic [3:0]  window_count;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FAST_SUM,
    ST_FAST_GRANT,
    ST_FAST_TAKE,
    ST_ADV_READ,
    ST_ADV_EVAL,
    ST_FIN_CHECK,
    ST_FIN_EVAL,
    ST_FIN_ACC,
    ST_SEEK_CHECK,
    ST_SEEK_EVAL,
    ST_SEEK_ACC,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_ARM,
    CMD_FAST_SUM,
    CMD_FAST_GRANT,
    CMD_FAST_TAKE,
    CMD_ADV_READ,
    CMD_ADV_STEP,
    CMD_SEEK_NEXT,
    CMD_WALK_READ,
    CMD_WALK_INC,
    CMD_MUL,
    CMD_FIN_ACC,
    CMD_SEEK_START,
    CMD_SEEK_ACC,
    CMD_SEEK_HIT,
    CMD_SEEK_MISS,
    CMD_COUNT,
    CMD_OUTPUT
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       walk_lt;
    logic       cur_lt;
    logic       ent_delay;
    logic       ent_sched;
    logic       ent_more;
    logic       out_free;
  } dp_status_t;

endpackage

### rtl/sag_req_if.sv
// request channel: packets, window writes and arm commands
interface sag_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [31:0]        packet_time;
  logic               fast_trigger;
  logic [2:0]         window_index;
  logic [15:0]        window_samples;
  logic signed [23:0] window_period;

  modport source (
    output valid, opcode, packet_time, fast_trigger, window_index, window_samples,
           window_period,
    input  ready
  );
  modport sink (
    input  valid, opcode, packet_time, fast_trigger, window_index, window_samples,
           window_period,
    output ready
  );
endinterface

### rtl/sag_rsp_if.sv
// result channel: store decision and counters
interface sag_rsp_if;
  logic        valid;
  logic        ready;
  logic        store;
  logic [31:0] stored_count;
  logic [23:0] fast_points_left;

  modport source (
    output valid, store, stored_count, fast_points_left,
    input  ready
  );
  modport sink (
    input  valid, store, stored_count, fast_points_left,
    output ready
  );
endinterface

### rtl/sag_ram.sv
// generic single write port ram with registered read
module sag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/sag_cfg.sv
// apb configuration registers
module sag_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sag_pkg::cfg_t cfg
);
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_fast_points    <= '0;
      cfg.points_per_trigger <= sag_pkg::GRANT_DEFAULT;
      cfg.window_count       <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sag_pkg::REG_MAX_FAST:  cfg.max_fast_points    <= pwdata[23:0];
        sag_pkg::REG_PER_TRIG:  cfg.points_per_trigger <= pwdata[23:0];
        sag_pkg::REG_WIN_COUNT: cfg.window_count       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      sag_pkg::REG_MAX_FAST:  prdata = {8'd0, cfg.max_fast_points};
      sag_pkg::REG_PER_TRIG:  prdata = {8'd0, cfg.points_per_trigger};
      sag_pkg::REG_WIN_COUNT: prdata = {28'd0, cfg.window_count};
      default:                prdata = '0;
    endcase
  end
endmodule

### rtl/sag_ctrl.sv
// controller: sequences each request through the datapath
module sag_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sag_pkg::dp_status_t status,
  output logic                ready,
  output sag_pkg::dp_cmd_t    cmd
);
  sag_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == sag_pkg::ST_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = sag_pkg::CMD_NONE;
    case (state)
      sag_pkg::ST_IDLE: begin
        if (accept) state_next = sag_pkg::ST_DISPATCH;
      end
      sag_pkg::ST_DISPATCH: begin
        case (status.op)
          sag_pkg::OP_PACKET: state_next = sag_pkg::ST_FAST_SUM;
          sag_pkg::OP_WRITE: begin
            cmd        = sag_pkg::CMD_WRITE;
            state_next = sag_pkg::ST_DONE;
          end
          sag_pkg::OP_ARM: begin
            cmd        = sag_pkg::CMD_ARM;
            state_next = sag_pkg::ST_FIN_CHECK;
          end
          default: state_next = sag_pkg::ST_DONE;
        endcase
      end
      sag_pkg::ST_FAST_SUM: begin
        cmd        = sag_pkg::CMD_FAST_SUM;
        state_next = sag_pkg::ST_FAST_GRANT;
      end
      sag_pkg::ST_FAST_GRANT: begin
        cmd        = sag_pkg::CMD_FAST_GRANT;
        state_next = sag_pkg::ST_FAST_TAKE;
      end
      sag_pkg::ST_FAST_TAKE: begin
        cmd        = sag_pkg::CMD_FAST_TAKE;
        state_next = status.hit ? sag_pkg::ST_ADV_READ : sag_pkg::ST_COUNT;
      end
      sag_pkg::ST_ADV_READ: begin
        if (status.cur_lt) begin
          cmd        = sag_pkg::CMD_ADV_READ;
          state_next = sag_pkg::ST_ADV_EVAL;
        end else begin
          cmd        = sag_pkg::CMD_SEEK_NEXT;
          state_next = sag_pkg::ST_SEEK_CHECK;
        end
      end
      sag_pkg::ST_ADV_EVAL: begin
        if (status.ent_more) begin
          cmd        = sag_pkg::CMD_ADV_STEP;
          state_next = sag_pkg::ST_COUNT;
        end else begin
          cmd        = sag_pkg::CMD_SEEK_NEXT;
          state_next = sag_pkg::ST_SEEK_CHECK;
        end
      end
      sag_pkg::ST_FIN_CHECK: begin
        if (status.walk_lt) begin
          cmd        = sag_pkg::CMD_WALK_READ;
          state_next = sag_pkg::ST_FIN_EVAL;
        end else begin
          cmd        = sag_pkg::CMD_SEEK_START;
          state_next = sag_pkg::ST_SEEK_CHECK;
        end
      end
      sag_pkg::ST_FIN_EVAL: begin
        if (status.ent_delay || status.ent_sched) begin
          cmd        = sag_pkg::CMD_MUL;
          state_next = sag_pkg::ST_FIN_ACC;
        end else begin
          cmd        = sag_pkg::CMD_WALK_INC;
          state_next = sag_pkg::ST_FIN_CHECK;
        end
      end
      sag_pkg::ST_FIN_ACC: begin
        cmd        = sag_pkg::CMD_FIN_ACC;
        state_next = sag_pkg::ST_FIN_CHECK;
      end
      sag_pkg::ST_SEEK_CHECK: begin
        if (status.walk_lt) begin
          cmd        = sag_pkg::CMD_WALK_READ;
          state_next = sag_pkg::ST_SEEK_EVAL;
        end else begin
          cmd        = sag_pkg::CMD_SEEK_MISS;
          state_next = sag_pkg::ST_COUNT;
        end
      end
      sag_pkg::ST_SEEK_EVAL: begin
        if (status.ent_delay) begin
          cmd        = sag_pkg::CMD_MUL;
          state_next = sag_pkg::ST_SEEK_ACC;
        end else if (status.ent_sched) begin
          cmd        = sag_pkg::CMD_SEEK_HIT;
          state_next = sag_pkg::ST_COUNT;
        end else begin
          cmd        = sag_pkg::CMD_WALK_INC;
          state_next = sag_pkg::ST_SEEK_CHECK;
        end
      end
      sag_pkg::ST_SEEK_ACC: begin
        cmd        = sag_pkg::CMD_SEEK_ACC;
        state_next = sag_pkg::ST_SEEK_CHECK;
      end
      sag_pkg::ST_COUNT: begin
        cmd        = sag_pkg::CMD_COUNT;
        state_next = sag_pkg::ST_DONE;
      end
      sag_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd        = sag_pkg::CMD_OUTPUT;
          state_next = sag_pkg::ST_IDLE;
        end
      end
      default: state_next = sag_pkg::ST_IDLE;
    endcase
  end
endmodule

### rtl/sag_dp.sv
// datapath: window table, schedule state, fast budget and result register
module sag_dp #(
  parameter int WINDOWS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  sag_pkg::cfg_t       cfg,
  input  sag_pkg::dp_cmd_t    cmd,
  output sag_pkg::dp_status_t status,
  // request payload
  input  logic                accept,
  input  logic [1:0]          opcode,
  input  logic [31:0]         packet_time,
  input  logic                fast_trigger,
  input  logic [2:0]          window_index,
  input  logic [15:0]         window_samples,
  input  logic [23:0]         window_period,
  // result register
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_store,
  output logic [31:0]         out_count,
  output logic [23:0]         out_fast
);
  localparam int WCW = $clog2(WINDOWS + 1);
  localparam int CW  = (WCW > 4) ? WCW : 4;
  localparam int AW  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;

  // captured request
  logic [1:0]  cap_op;
  logic [31:0] cap_time;
  logic        cap_trig;
  logic [2:0]  cap_idx;
  logic [15:0] cap_samples;
  logic [23:0] cap_period;

  // architectural state
  logic [23:0] fast_left;
  logic [23:0] fast_pending;
  logic [CW-1:0] cur_win;
  logic [15:0] sample_in_window;
  logic [31:0] next_time;
  logic [31:0] final_time;
  logic        active;
  logic [31:0] store_counter;
  logic        sflag;

  // table walk
  logic [CW-1:0] widx;
  logic [31:0]   tacc;
  logic [31:0]   prod;

  // table storage
  logic [WINDOWS-1:0]           ent_valid;
  logic                         rd_valid;
  logic [sag_pkg::ENTRY_W-1:0]  ram_q;
  logic [sag_pkg::ENTRY_W-1:0]  ent;
  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [AW-1:0]                ram_waddr;

  // entry decode
  logic [23:0] ent_raw;
  logic [15:0] ent_cnt;
  logic [23:0] ent_mag;
  logic [39:0] prod_full;
  logic        ent_delay;
  logic        ent_sched;
  logic        ent_more;
  logic [CW-1:0] used;
  logic [23:0] grant;
  logic        idx_ok;

  // capture on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cap_op      <= opcode;
      cap_time    <= packet_time;
      cap_trig    <= fast_trigger;
      cap_idx     <= window_index;
      cap_samples <= window_samples;
      cap_period  <= window_period;
    end
  end

  // windows in use, clamped to the table size
  assign used = (CW'(cfg.window_count) > CW'(WINDOWS)) ? CW'(WINDOWS) : CW'(cfg.window_count);

  // table write and read control
  assign idx_ok    = (32'(cap_idx) < WINDOWS);
  assign ram_we    = (cmd == sag_pkg::CMD_WRITE) && idx_ok;
  assign ram_waddr = AW'(cap_idx);
  assign ram_re    = (cmd == sag_pkg::CMD_ADV_READ) || (cmd == sag_pkg::CMD_WALK_READ);
  assign ram_raddr = (cmd == sag_pkg::CMD_ADV_READ) ? cur_win[AW-1:0] : widx[AW-1:0];

  sag_ram #(
    .WIDTH (sag_pkg::ENTRY_W),
    .DEPTH (WINDOWS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cap_samples, cap_period}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // written flags; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ram_we) ent_valid[ram_waddr] <= 1'b1;
      if (ram_re) rd_valid <= ent_valid[ram_raddr];
    end
  end

  assign ent       = rd_valid ? ram_q : '0;
  assign ent_raw   = ent[23:0];
  assign ent_cnt   = ent[39:24];
  assign ent_delay = ent_raw[23];
  assign ent_mag   = ent_delay ? (24'd0 - ent_raw) : ent_raw;
  assign ent_sched = !ent_delay && (ent_raw != '0) && (ent_cnt != '0);
  assign ent_more  = !ent_delay && (ent_raw != '0) &&
                     ((17'(sample_in_window) + 17'd1) < 17'(ent_cnt));
  assign prod_full = ent_mag * ent_cnt;

  assign grant = (fast_left < cfg.points_per_trigger) ? fast_left : cfg.points_per_trigger;

  // status to the controller
  assign status.op        = cap_op;
  assign status.hit       = active && (cap_time >= next_time) && (cap_time <= final_time);
  assign status.walk_lt   = (widx < used);
  assign status.cur_lt    = (cur_win < used);
  assign status.ent_delay = ent_delay;
  assign status.ent_sched = ent_sched;
  assign status.ent_more  = ent_more;
  assign status.out_free  = !out_valid || out_ready;

  // walk registers
  always_ff @(posedge clk) begin
    case (cmd)
      sag_pkg::CMD_ARM, sag_pkg::CMD_SEEK_START: begin
        widx <= '0;
        tacc <= '0;
      end
      sag_pkg::CMD_SEEK_NEXT: begin
        widx <= cur_win + CW'(1);
        tacc <= next_time;
      end
      sag_pkg::CMD_WALK_INC: widx <= widx + CW'(1);
      sag_pkg::CMD_MUL:      prod <= prod_full[31:0];
      sag_pkg::CMD_FIN_ACC, sag_pkg::CMD_SEEK_ACC: begin
        tacc <= tacc + prod;
        widx <= widx + CW'(1);
      end
      default: ;
    endcase
  end

  // schedule, budget and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_left        <= '0;
      fast_pending     <= '0;
      cur_win          <= '0;
      sample_in_window <= '0;
      next_time        <= '0;
      final_time       <= '0;
      active           <= 1'b0;
      store_counter    <= '0;
      sflag            <= 1'b0;
    end else begin
      if (accept) sflag <= 1'b0;
      case (cmd)
        sag_pkg::CMD_ARM: begin
          final_time       <= '0;
          cur_win          <= '0;
          sample_in_window <= '0;
          next_time        <= '0;
          store_counter    <= '0;
          fast_left        <= cfg.max_fast_points;
          fast_pending     <= '0;
        end
        sag_pkg::CMD_FAST_SUM: begin
          if (cap_trig) fast_left <= fast_left + fast_pending;
        end
        sag_pkg::CMD_FAST_GRANT: begin
          if (cap_trig) begin
            fast_pending <= grant;
            fast_left    <= fast_left - grant;
          end
        end
        sag_pkg::CMD_FAST_TAKE: begin
          if (fast_pending != '0) fast_pending <= fast_pending - 24'd1;
          sflag <= (fast_pending != '0) || status.hit;
        end
        sag_pkg::CMD_ADV_STEP: begin
          sample_in_window <= sample_in_window + 16'd1;
          next_time        <= next_time + {8'd0, ent_raw};
        end
        sag_pkg::CMD_FIN_ACC: begin
          if (!ent_delay) final_time <= tacc + prod;
        end
        sag_pkg::CMD_SEEK_HIT: begin
          cur_win          <= widx;
          sample_in_window <= '0;
          next_time        <= tacc + {8'd0, ent_raw};
          active           <= 1'b1;
        end
        sag_pkg::CMD_SEEK_MISS: active <= 1'b0;
        sag_pkg::CMD_COUNT: begin
          if (sflag) store_counter <= store_counter + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == sag_pkg::CMD_OUTPUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == sag_pkg::CMD_OUTPUT) begin
      out_store <= sflag;
      out_count <= store_counter;
      out_fast  <= fast_left;
    end
  end
endmodule

### rtl/sample_acquisition_gate_unit.sv
// Sample acquisition gate: per-packet store decision against a window schedule.
// The req channel carries one request at a time: a timestamped packet, a write
// of one window table entry, or an arm for the next pulse. Every request gives
// exactly one result on the rsp channel: the store bit, the stored count since
// arm and the fast budget still to be granted.
// A packet that moves on to a later window and an arm walk the window table one
// entry at a time, since the table has a single read port and one shared
// multiplier forms each window's time span. Arm walks the windows in use twice,
// once on the final-time pass and again on the seek pass. The next request is
// accepted the cycle after a result is loaded.
// Requests are taken one at a time; req.ready is high whenever no request is in
// work, including while a finished result waits in the output register. A stall
// on rsp.ready holds that result and the next request then waits at its end.
// Reset (rst, synchronous) clears the table to zero, disarms the schedule and
// restores the register defaults (grant per trigger 500). The apb port writes
// and reads the three configuration registers at byte addresses 0, 4 and 8.
module sample_acquisition_gate_unit #(
  parameter int WINDOWS = 8
) (
  input  logic        clk,
  input  logic        rst,
  sag_req_if.sink     req,
  sag_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  sag_pkg::cfg_t       cfg;
  sag_pkg::dp_cmd_t    cmd;
  sag_pkg::dp_status_t status;
  logic                ready;
  logic                accept;

  assign req.ready = ready;
  assign accept    = req.valid && ready;

  // configuration registers
  sag_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencing
  sag_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .ready  (ready),
    .cmd    (cmd)
  );

  // schedule and budget datapath
  sag_dp #(
    .WINDOWS (WINDOWS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .accept         (accept),
    .opcode         (req.opcode),
    .packet_time    (req.packet_time),
    .fast_trigger   (req.fast_trigger),
    .window_index   (req.window_index),
    .window_samples (req.window_samples),
    .window_period  (req.window_period),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_store      (rsp.store),
    .out_count      (rsp.stored_count),
    .out_fast       (rsp.fast_points_left)
  );
endmodule

### tb/sv/sample_acquisition_gate_unit_tb.sv
// testbench for the sample acquisition gate: directed plan, random schedules, scoreboard
`timescale 1ns / 1ps

module sample_acquisition_gate_unit_tb;

  localparam int          TABLE_DEPTH  = 8;
  localparam int          RAND_PHASES  = 6;
  localparam int          STREAM_LEN   = 110;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PERCENT = 22;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] packet_time;
    logic        fast_trigger;
    logic [2:0]  window_index;
    logic [15:0] window_samples;
    logic [23:0] window_period;
  } gate_request_t;

  typedef struct packed {
    logic        store;
    logic [31:0] stored_count;
    logic [23:0] fast_points_left;
  } gate_result_t;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  // one line of the directed plan: a request or a register write
  typedef struct packed {
    row_kind_t     kind;
    logic [1:0]    reg_index;
    logic [23:0]   reg_value;
    gate_request_t rq;
    logic          fixed;
    gate_result_t  want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sag_req_if req_ch ();
  sag_rsp_if rsp_ch ();

  sample_acquisition_gate_unit #(.WINDOWS(TABLE_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // predicted gate state
  logic [15:0] win_count_tbl  [TABLE_DEPTH];
  logic [23:0] win_period_tbl [TABLE_DEPTH];
  logic [23:0] budget_left;
  logic [23:0] grant_running;
  int unsigned win_cursor;
  int unsigned sample_cursor;
  logic [31:0] next_due;
  logic [31:0] last_due;
  bit          schedule_live;
  logic [31:0] stores_since_arm;
  logic [23:0] max_fast_cfg;
  logic [23:0] per_trigger_cfg;
  logic [3:0]  window_count_cfg;

  // scoreboard and traffic control
  gate_result_t expected_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  requests_sent = 0;
  int unsigned  arms_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  stores_seen = 0;
  bit           steady_traffic = 1'b0;
  bit           hold_request = 1'b0;

  function automatic void reset_prediction();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      win_count_tbl[i] = '0;
      win_period_tbl[i] = '0;
    end
    budget_left = '0;
    grant_running = '0;
    win_cursor = 0;
    sample_cursor = 0;
    next_due = '0;
    last_due = '0;
    schedule_live = 1'b0;
    stores_since_arm = '0;
    max_fast_cfg = '0;
    per_trigger_cfg = sag_pkg::GRANT_DEFAULT;
    window_count_cfg = '0;
  endfunction

  function automatic int unsigned windows_in_use();
    return (window_count_cfg < TABLE_DEPTH) ? window_count_cfg : TABLE_DEPTH;
  endfunction

  // time covered by a window, wrapping at 32 bits
  function automatic logic [31:0] window_span(logic [23:0] period, logic [15:0] count);
    logic [31:0] mag;
    logic [63:0] prod;
    mag = period[23] ? (32'h0100_0000 - {8'd0, period}) : {8'd0, period};
    prod = mag * count;
    return prod[31:0];
  endfunction

  // first acquisition time at or after window 'from', walking delays
  function automatic void seek_schedule(int unsigned from, logic [31:0] base);
    for (int unsigned w = from; w < windows_in_use(); w++) begin
      if (win_period_tbl[w][23]) begin
        base += window_span(win_period_tbl[w], win_count_tbl[w]);
      end else if (win_period_tbl[w] != 0 && win_count_tbl[w] != 0) begin
        win_cursor = w;
        sample_cursor = 0;
        next_due = base + {8'd0, win_period_tbl[w]};
        schedule_live = 1'b1;
        return;
      end
    end
    schedule_live = 1'b0;
  endfunction

  function automatic void arm_schedule();
    logic [31:0] t;
    t = '0;
    last_due = '0;
    for (int unsigned w = 0; w < windows_in_use(); w++) begin
      if (win_period_tbl[w][23]) begin
        t += window_span(win_period_tbl[w], win_count_tbl[w]);
      end else if (win_period_tbl[w] != 0 && win_count_tbl[w] != 0) begin
        t += window_span(win_period_tbl[w], win_count_tbl[w]);
        last_due = t;
      end
    end
    win_cursor = 0;
    sample_cursor = 0;
    next_due = '0;
    seek_schedule(0, '0);
    stores_since_arm = '0;
    budget_left = max_fast_cfg;
    grant_running = '0;
  endfunction

  // consume one acquisition time: next sample of this window or move on
  function automatic void step_schedule();
    int unsigned w;
    w = win_cursor;
    if (w < windows_in_use()) begin
      if (!win_period_tbl[w][23] && win_period_tbl[w] != 0 &&
          sample_cursor + 1 < win_count_tbl[w]) begin
        sample_cursor++;
        next_due += {8'd0, win_period_tbl[w]};
        return;
      end
    end
    seek_schedule(w + 1, next_due);
  endfunction

  // store decision and counters for one accepted request
  function automatic gate_result_t predict_request(gate_request_t rq);
    gate_result_t r;
    logic [23:0]  grant;
    bit           stored;
    stored = 1'b0;
    case (rq.opcode)
      sag_pkg::OP_PACKET: begin
        if (rq.fast_trigger) begin
          budget_left = budget_left + grant_running;
          grant = (budget_left < per_trigger_cfg) ? budget_left : per_trigger_cfg;
          grant_running = grant;
          budget_left -= grant;
        end
        if (grant_running != 0) begin
          grant_running--;
          stored = 1'b1;
        end
        if (schedule_live && rq.packet_time >= next_due && rq.packet_time <= last_due) begin
          step_schedule();
          stored = 1'b1;
        end
        if (stored) stores_since_arm++;
      end
      sag_pkg::OP_WRITE: begin
        win_count_tbl[rq.window_index] = rq.window_samples;
        win_period_tbl[rq.window_index] = rq.window_period;
      end
      sag_pkg::OP_ARM: arm_schedule();
      default: ;
    endcase
    r.store = stored;
    r.stored_count = stores_since_arm;
    r.fast_points_left = budget_left;
    return r;
  endfunction

  // plan row builders
  function automatic plan_row_t req_row(logic [1:0] op, logic [31:0] t, logic trig,
                                        logic [2:0] idx, logic [15:0] smp, logic [23:0] per);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.rq = '{op, t, trig, idx, smp, per};
    return row;
  endfunction

  function automatic plan_row_t pkt(logic [31:0] t, logic trig);
    return req_row(sag_pkg::OP_PACKET, t, trig, 3'd0, 16'd0, 24'd0);
  endfunction

  function automatic plan_row_t win(logic [2:0] idx, logic [15:0] smp, logic [23:0] per);
    return req_row(sag_pkg::OP_WRITE, 32'd0, 1'b0, idx, smp, per);
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [23:0] value);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REGISTER;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  function automatic plan_row_t fixed_result(plan_row_t row, logic st, logic [31:0] cnt,
                                             logic [23:0] left);
    row.fixed = 1'b1;
    row.want = '{st, cnt, left};
    return row;
  endfunction

  // random request generators
  function automatic gate_request_t random_fields();
    gate_request_t rq;
    rq.opcode = 2'($urandom);
    rq.packet_time = $urandom;
    rq.fast_trigger = 1'($urandom);
    rq.window_index = 3'($urandom);
    rq.window_samples = 16'($urandom);
    rq.window_period = 24'($urandom);
    return rq;
  endfunction

  // mostly short windows with small periods so the schedule is reachable
  function automatic gate_request_t random_window_write(logic [2:0] idx);
    gate_request_t rq;
    int unsigned   pick;
    rq = random_fields();
    rq.opcode = sag_pkg::OP_WRITE;
    rq.window_index = idx;
    if ($urandom_range(99) < 12) rq.window_samples = 16'($urandom);
    else rq.window_samples = 16'($urandom_range(0, 6));
    pick = $urandom_range(99);
    if (pick < 45) rq.window_period = 24'($urandom_range(1, 150));
    else if (pick < 75) rq.window_period = 24'(-int'($urandom_range(1, 200)));
    else if (pick < 85) rq.window_period = '0;
    return rq;
  endfunction

  // apb write, predictor register copy follows at the access edge
  task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sag_pkg::REG_MAX_FAST:  max_fast_cfg = value;
      sag_pkg::REG_PER_TRIG:  per_trigger_cfg = value;
      sag_pkg::REG_WIN_COUNT: window_count_cfg = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // offer one request, predict its result once accepted
  task automatic offer_request(input gate_request_t rq, input logic fixed,
                               input gate_result_t want);
    gate_result_t predicted;
    if (!steady_traffic) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= rq.opcode;
    req_ch.packet_time <= rq.packet_time;
    req_ch.fast_trigger <= rq.fast_trigger;
    req_ch.window_index <= rq.window_index;
    req_ch.window_samples <= rq.window_samples;
    req_ch.window_period <= rq.window_period;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_request(rq);
    expected_results.push_back(fixed ? want : predicted);
    requests_sent++;
    if (rq.opcode == sag_pkg::OP_ARM) arms_sent++;
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_result();
    gate_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("result with no request outstanding: store %0d count %0d left %0d",
             rsp_ch.store, rsp_ch.stored_count, rsp_ch.fast_points_left);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (rsp_ch.store !== want.store) begin
        $error("store: expected %0d, got %0d", want.store, rsp_ch.store);
        mismatch_count++;
      end
      if (rsp_ch.stored_count !== want.stored_count) begin
        $error("stored_count: expected %0d, got %0d", want.stored_count, rsp_ch.stored_count);
        mismatch_count++;
      end
      if (rsp_ch.fast_points_left !== want.fast_points_left) begin
        $error("fast_points_left: expected %0d, got %0d", want.fast_points_left,
               rsp_ch.fast_points_left);
        mismatch_count++;
      end
      if (want.store) stores_seen++;
    end
  endtask

  // result side: check, then random ready with an occasional long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady_traffic || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // run limit
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    plan_row_t     plan[$];
    gate_request_t rq;
    logic [23:0]   max_pick;
    logic [23:0]   per_pick;
    logic [3:0]    count_pick;
    logic [31:0]   now_us;
    int unsigned   roll;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= sag_pkg::OP_NOP;
    req_ch.packet_time <= '0;
    req_ch.fast_trigger <= 1'b0;
    req_ch.window_index <= '0;
    req_ch.window_samples <= '0;
    req_ch.window_period <= '0;
    reset_prediction();
    now_us = '0;

    // nothing armed yet: nop, empty fast budget, extreme timestamp
    plan.push_back(fixed_result(req_row(sag_pkg::OP_NOP, 32'hFFFF_FFFF, 1'b1, 3'd7, 16'hFFFF,
                                        24'h800000), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(pkt(32'd0, 1'b1), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(pkt(32'hFFFF_FFFF, 1'b0), 1'b0, 32'd0, 24'd0));
    // small budget, window count above the table size
    plan.push_back(reg_row(sag_pkg::REG_MAX_FAST, 24'd3));
    plan.push_back(reg_row(sag_pkg::REG_PER_TRIG, 24'd2));
    plan.push_back(reg_row(sag_pkg::REG_WIN_COUNT, 24'd15));
    // delay, schedule, zero count, zero period, wrapping max delay, max period
    plan.push_back(fixed_result(win(3'd0, 16'd2, -24'sd100), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(win(3'd1, 16'd3, 24'd50), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(win(3'd2, 16'd0, 24'd10), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(win(3'd3, 16'd5, 24'd0), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(win(3'd4, 16'hFFFF, 24'h800000), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(win(3'd5, 16'd2, 24'h7FFFFF), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(win(3'd7, 16'hFFFF, 24'd0), 1'b0, 32'd0, 24'd0));
    plan.push_back(fixed_result(req_row(sag_pkg::OP_ARM, 32'd0, 1'b0, 3'd0, 16'd0, 24'd0),
                                1'b0, 32'd0, 24'd3));
    // early, on time, fast grants overlapping, past final, wrapped schedule time
    plan.push_back(pkt(32'd0, 1'b0));
    plan.push_back(pkt(32'd249, 1'b0));
    plan.push_back(pkt(32'd250, 1'b1));
    plan.push_back(pkt(32'd260, 1'b0));
    plan.push_back(pkt(32'd260, 1'b1));
    plan.push_back(pkt(32'd300, 1'b0));
    plan.push_back(pkt(32'hFFFF_FFFF, 1'b0));
    plan.push_back(pkt(32'd350, 1'b0));
    plan.push_back(pkt(32'd351, 1'b0));
    // table rewritten while armed
    plan.push_back(win(3'd1, 16'd1, 24'd40));
    // zero grant per trigger, full budget, no windows
    plan.push_back(reg_row(sag_pkg::REG_PER_TRIG, 24'd0));
    plan.push_back(reg_row(sag_pkg::REG_MAX_FAST, 24'hFFFFFF));
    plan.push_back(reg_row(sag_pkg::REG_WIN_COUNT, 24'd0));
    plan.push_back(fixed_result(req_row(sag_pkg::OP_ARM, 32'd0, 1'b0, 3'd0, 16'd0, 24'd0),
                                1'b0, 32'd0, 24'hFFFFFF));
    plan.push_back(pkt(32'd100, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGISTER) begin
        wait_drained();
        write_register(plan[i].reg_index, plan[i].reg_value);
      end else begin
        offer_request(plan[i].rq, plan[i].fixed, plan[i].want);
      end
    end

    // random phases: fresh settings, fresh table, arm, then a packet stream
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          max_pick = 24'hFFFFFF;
          per_pick = 24'hFFFFFF;
          count_pick = 4'd15;
        end
        1: begin
          max_pick = '0;
          per_pick = '0;
          count_pick = 4'd8;
        end
        default: begin
          max_pick = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 60));
          per_pick = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12));
          count_pick = 4'($urandom_range(0, 15));
        end
      endcase
      write_register(sag_pkg::REG_MAX_FAST, max_pick);
      write_register(sag_pkg::REG_PER_TRIG, per_pick);
      write_register(sag_pkg::REG_WIN_COUNT, {20'd0, count_pick});
      steady_traffic = (phase == 4);

      for (int idx = 0; idx < TABLE_DEPTH; idx++) begin
        offer_request(random_window_write(3'(idx)), 1'b0, '0);
      end
      rq = random_fields();
      rq.opcode = sag_pkg::OP_ARM;
      offer_request(rq, 1'b0, '0);
      now_us = '0;

      for (int i = 0; i < STREAM_LEN; i++) begin
        // long result stall while requests keep coming
        if (phase == 2 && i == 30) hold_request = 1'b1;
        // sender pause until everything is back
        if (phase == 3 && i == 55) wait_drained();
        roll = $urandom_range(99);
        if (roll < 4) begin
          rq = random_window_write(3'($urandom));
        end else begin
          rq = random_fields();
          if (roll < 6) begin
            rq.opcode = sag_pkg::OP_NOP;
          end else if (roll < 7) begin
            rq.opcode = sag_pkg::OP_ARM;
            now_us = '0;
          end else begin
            rq.opcode = sag_pkg::OP_PACKET;
            rq.fast_trigger = ($urandom_range(99) < 6);
            // most packets march forward in time, some carry a stray timestamp
            if (roll >= 15) begin
              now_us += $urandom_range(0, 80);
              rq.packet_time = now_us;
            end
          end
        end
        offer_request(rq, 1'b0, '0);
      end
    end
    steady_traffic = 1'b0;

    wait_drained();
    repeat (64) @(posedge clk);
    $display("run covered %0d requests including %0d arms over %0d random phases",
             requests_sent, arms_sent, RAND_PHASES);
    $display("checked %0d results, %0d of them stored packets", results_seen, stores_seen);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
